@@ design/clb_pkg.sv @@
// ----------------------------------------------------------------------------
// clb_pkg: shared types and constants for the crossing angle boost
// Payload structs of the request and response channels, register indexes,
// register reset values and the widths of the square root pipeline.
// ----------------------------------------------------------------------------
package clb_pkg;

   // fixed point field widths
   localparam int FIELD_W = 32;
   localparam int MASS_W  = 31;
   localparam int CSR_W   = 32;

   // square root pipeline: 64 bit radicand, one root bit per stage
   localparam int RAD_W       = 2 * FIELD_W;
   localparam int ROOT_W      = FIELD_W;
   localparam int REM_W       = ROOT_W + 2;
   localparam int SQRT_STAGES = ROOT_W;

   // configuration register indexes
   localparam int CFG_IDX_W = 2;
   typedef enum logic [CFG_IDX_W-1:0] {
      CFG_LORENTZ_GAMMA    = 2'd0,
      CFG_BETA_GAMMA       = 2'd1,
      CFG_BETA_GAMMA_LIGHT = 2'd2
   } cfg_index_type;

   // register reset values, identity boost
   localparam logic [CSR_W-1:0] GAMMA_RESET = 32'h4000_0000;
   localparam logic [CSR_W-1:0] BG_RESET    = 32'h0000_0000;
   localparam logic [CSR_W-1:0] BGL_RESET   = 32'h0000_0000;

   // one particle
   typedef struct packed {
      logic signed [FIELD_W-1:0] vertex_x;
      logic signed [FIELD_W-1:0] vertex_y;
      logic signed [FIELD_W-1:0] vertex_z;
      logic signed [FIELD_W-1:0] prod_time;
      logic signed [FIELD_W-1:0] mom_x;
      logic signed [FIELD_W-1:0] mom_y;
      logic signed [FIELD_W-1:0] mom_z;
      logic [MASS_W-1:0]         rest_mass;
   } req_payload_type;

   // one boosted particle
   typedef struct packed {
      logic signed [FIELD_W-1:0] boosted_vertex_x;
      logic signed [FIELD_W-1:0] out_vertex_y;
      logic signed [FIELD_W-1:0] out_vertex_z;
      logic signed [FIELD_W-1:0] boosted_mom_x;
      logic signed [FIELD_W-1:0] out_mom_y;
      logic signed [FIELD_W-1:0] out_mom_z;
   } rsp_payload_type;

endpackage

@@ design/clb_req_if.sv @@
// ----------------------------------------------------------------------------
// clb_req_if: request channel
// Valid/ready channel carrying one particle per beat.
// ----------------------------------------------------------------------------
interface clb_req_if;
   logic                     valid;
   logic                     ready;
   clb_pkg::req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

@@ design/clb_rsp_if.sv @@
// ----------------------------------------------------------------------------
// clb_rsp_if: response channel
// Valid/ready channel carrying one boosted particle per beat.
// ----------------------------------------------------------------------------
interface clb_rsp_if;
   logic                     valid;
   logic                     ready;
   clb_pkg::rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

@@ design/clb_isqrt_pipe.sv @@
// ----------------------------------------------------------------------------
// clb_isqrt_pipe: pipelined integer square root
// Floor square root of a 64 bit radicand, one root bit resolved per register
// stage by a compare and subtract. A common enable freezes every stage.
// ----------------------------------------------------------------------------
module clb_isqrt_pipe (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic                        in_vld,
   input  logic [clb_pkg::RAD_W-1:0]   in_rad,
   output logic                        out_vld,
   output logic [clb_pkg::ROOT_W-1:0]  out_root
);
   import clb_pkg::*;

   localparam int LAST = SQRT_STAGES - 1;

   logic              vld_ff  [SQRT_STAGES];
   logic [ROOT_W-1:0] root_ff [SQRT_STAGES];
   logic [REM_W-1:0]  rem_ff  [LAST];
   logic [RAD_W-1:0]  rad_ff  [LAST];

   for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_step
      logic              src_vld;
      logic [REM_W-1:0]  src_rem;
      logic [ROOT_W-1:0] src_root;
      logic [RAD_W-1:0]  src_rad;
      logic [REM_W-1:0]  cur;
      logic [REM_W-1:0]  trial;
      logic [REM_W-1:0]  rem_in;
      logic [ROOT_W-1:0] root_in;

      // stage input: module port or previous stage
      if (k == 0) begin : g_first
         assign src_vld  = in_vld;
         assign src_rem  = '0;
         assign src_root = '0;
         assign src_rad  = in_rad;
      end else begin : g_next
         assign src_vld  = vld_ff[k-1];
         assign src_rem  = rem_ff[k-1];
         assign src_root = root_ff[k-1];
         assign src_rad  = rad_ff[k-1];
      end

      // bring down two radicand bits, try root bit one
      assign cur   = {src_rem[REM_W-3:0], src_rad[RAD_W-1 -: 2]};
      assign trial = {src_root, 2'b01};

      always_comb begin
         if (cur >= trial) begin
            rem_in  = cur - trial;
            root_in = {src_root[ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = cur;
            root_in = {src_root[ROOT_W-2:0], 1'b0};
         end
      end

      // stage valid
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (en) begin
            vld_ff[k] <= src_vld;
         end
      end

      // stage root
      always_ff @(posedge clock) begin
         if (en) begin
            root_ff[k] <= root_in;
         end
      end

      // remainder and radicand go on to the next stage only
      if (k < LAST) begin : g_carry
         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[k] <= rem_in;
               rad_ff[k] <= {src_rad[RAD_W-3:0], 2'b00};
            end
         end
      end
   end

   assign out_vld  = vld_ff[LAST];
   assign out_root = root_ff[LAST];

endmodule

@@ design/crossing_angle_lorentz_boost_top.sv @@
// ----------------------------------------------------------------------------
// crossing_angle_lorentz_boost_top: Lorentz boost along x
// Energy from the momenta and mass, then x and px boosted with the gamma and
// beta-gamma registers; y and z pass through. Boosted values are rounded to
// nearest and saturated to Q16.16.
//
//   port      direction  beat
//   req_chan  in         vertex, production time, momentum, rest mass
//   rsp_chan  out        boosted vertex x and px, y and z unchanged
//   csr_*     in         register writes, no read-back
//
// One particle enters every cycle unless the response stalls; the pipeline is
// three stages of squares and sums, 32 square root stages (one root bit each),
// one multiply stage and the output register.
// A stalled response freezes the whole pipeline; nothing is dropped.
// Reset clears all valid bits and loads the identity boost.
// ----------------------------------------------------------------------------
module crossing_angle_lorentz_boost_top (
   input  logic                           clock,
   input  logic                           reset,
   clb_req_if.sink                        req_chan,
   clb_rsp_if.source                      rsp_chan,
   input  logic                           csr_we,
   input  logic [clb_pkg::CFG_IDX_W-1:0]  csr_index,
   input  logic [clb_pkg::CSR_W-1:0]      csr_wdata
);
   import clb_pkg::*;

   localparam logic signed [65:0] SAT_MAX   = 66'sd2147483647;
   localparam logic signed [65:0] SAT_MIN   = -66'sd2147483648;
   localparam logic signed [65:0] HALF_Q16  = 66'sd32768;
   localparam logic signed [65:0] HALF_Q30  = 66'sd536870912;

   typedef struct packed {
      logic signed [FIELD_W-1:0] nx;
      logic signed [FIELD_W-1:0] vy;
      logic signed [FIELD_W-1:0] vz;
      logic signed [FIELD_W-1:0] px;
      logic signed [FIELD_W-1:0] py;
      logic signed [FIELD_W-1:0] pz;
   } side_type;

   function automatic logic [FIELD_W-1:0] abs_q16(input logic signed [FIELD_W-1:0] v);
      return v[FIELD_W-1] ? FIELD_W'(-v) : FIELD_W'(v);
   endfunction

   function automatic logic signed [FIELD_W-1:0] sat_q16(input logic signed [65:0] v);
      logic signed [FIELD_W-1:0] r;
      if (v > SAT_MAX) begin
         r = SAT_MAX[FIELD_W-1:0];
      end else if (v < SAT_MIN) begin
         r = SAT_MIN[FIELD_W-1:0];
      end else begin
         r = v[FIELD_W-1:0];
      end
      return r;
   endfunction

   // configuration registers
   logic [CSR_W-1:0]        gamma_ff;
   logic signed [CSR_W-1:0] bg_ff;
   logic signed [CSR_W-1:0] bgl_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         gamma_ff <= GAMMA_RESET;
         bg_ff    <= BG_RESET;
         bgl_ff   <= BGL_RESET;
      end else if (csr_we) begin
         case (cfg_index_type'(csr_index))
            CFG_LORENTZ_GAMMA:    gamma_ff <= csr_wdata;
            CFG_BETA_GAMMA:       bg_ff    <= csr_wdata;
            CFG_BETA_GAMMA_LIGHT: bgl_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // pipeline advance: output empty or being taken
   logic en;
   logic out_vld_ff;
   logic req_fire;

   assign en             = !out_vld_ff || rsp_chan.ready;
   assign req_chan.ready = en;
   assign req_fire       = req_chan.valid && en;

   // stage 1: squares and the vertex products
   logic                      s1_vld_ff;
   logic [RAD_W-1:0]          s1_sq_ff [4];
   logic signed [64:0]        s1_gvx_ff;
   logic signed [63:0]        s1_bgt_ff;
   logic signed [FIELD_W-1:0] s1_vy_ff, s1_vz_ff, s1_px_ff, s1_py_ff, s1_pz_ff;
   logic [FIELD_W-1:0]        abs_x, abs_y, abs_z, mass_w;

   assign abs_x  = abs_q16(req_chan.payload.mom_x);
   assign abs_y  = abs_q16(req_chan.payload.mom_y);
   assign abs_z  = abs_q16(req_chan.payload.mom_z);
   assign mass_w = {1'b0, req_chan.payload.rest_mass};

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (en) begin
         s1_vld_ff <= req_fire;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_sq_ff[0] <= abs_x * abs_x;
         s1_sq_ff[1] <= abs_y * abs_y;
         s1_sq_ff[2] <= abs_z * abs_z;
         s1_sq_ff[3] <= mass_w * mass_w;
         s1_gvx_ff   <= $signed({1'b0, gamma_ff}) * req_chan.payload.vertex_x;
         s1_bgt_ff   <= bgl_ff * req_chan.payload.prod_time;
         s1_vy_ff    <= req_chan.payload.vertex_y;
         s1_vz_ff    <= req_chan.payload.vertex_z;
         s1_px_ff    <= req_chan.payload.mom_x;
         s1_py_ff    <= req_chan.payload.mom_y;
         s1_pz_ff    <= req_chan.payload.mom_z;
      end
   end

   // stage 2: pair sums, vertex sum with rounding offset
   logic                      s2_vld_ff;
   logic [RAD_W-1:0]          s2_s01_ff, s2_s23_ff;
   logic signed [65:0]        s2_nxs_ff;
   logic signed [FIELD_W-1:0] s2_vy_ff, s2_vz_ff, s2_px_ff, s2_py_ff, s2_pz_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else if (en) begin
         s2_vld_ff <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2_s01_ff <= s1_sq_ff[0] + s1_sq_ff[1];
         s2_s23_ff <= s1_sq_ff[2] + s1_sq_ff[3];
         s2_nxs_ff <= 66'(s1_gvx_ff >>> 14) + 66'(s1_bgt_ff) + HALF_Q16;
         s2_vy_ff  <= s1_vy_ff;
         s2_vz_ff  <= s1_vz_ff;
         s2_px_ff  <= s1_px_ff;
         s2_py_ff  <= s1_py_ff;
         s2_pz_ff  <= s1_pz_ff;
      end
   end

   // stage 3: radicand, boosted x rounded and saturated
   logic             s3_vld_ff;
   logic [RAD_W-1:0] s3_rad_ff;
   side_type         s3_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_vld_ff <= 1'b0;
      end else if (en) begin
         s3_vld_ff <= s2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s3_rad_ff     <= s2_s01_ff + s2_s23_ff;
         s3_side_ff.nx <= sat_q16(s2_nxs_ff >>> 16);
         s3_side_ff.vy <= s2_vy_ff;
         s3_side_ff.vz <= s2_vz_ff;
         s3_side_ff.px <= s2_px_ff;
         s3_side_ff.py <= s2_py_ff;
         s3_side_ff.pz <= s2_pz_ff;
      end
   end

   // energy square root
   logic              sq_vld;
   logic [ROOT_W-1:0] sq_root;

   clb_isqrt_pipe u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_vld   (s3_vld_ff),
      .in_rad   (s3_rad_ff),
      .out_vld  (sq_vld),
      .out_root (sq_root)
   );

   // side fields ride along the square root stages
   side_type side_ff [SQRT_STAGES];

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= s3_side_ff;
         for (int k = 1; k < SQRT_STAGES; k++) begin
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   // stage 4: momentum products
   logic               s4_vld_ff;
   logic signed [64:0] s4_bge_ff, s4_gpx_ff;
   side_type           s4_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_vld_ff <= 1'b0;
      end else if (en) begin
         s4_vld_ff <= sq_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s4_bge_ff  <= bg_ff * $signed({1'b0, sq_root});
         s4_gpx_ff  <= $signed({1'b0, gamma_ff}) * side_ff[SQRT_STAGES-1].px;
         s4_side_ff <= side_ff[SQRT_STAGES-1];
      end
   end

   // output register: boosted px rounded and saturated
   logic signed [65:0] npx_sum;
   rsp_payload_type    out_ff;

   assign npx_sum = 66'(s4_bge_ff) + 66'(s4_gpx_ff) + HALF_Q30;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (en) begin
         out_vld_ff <= s4_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_ff.boosted_vertex_x <= s4_side_ff.nx;
         out_ff.out_vertex_y     <= s4_side_ff.vy;
         out_ff.out_vertex_z     <= s4_side_ff.vz;
         out_ff.boosted_mom_x    <= sat_q16(npx_sum >>> 30);
         out_ff.out_mom_y        <= s4_side_ff.py;
         out_ff.out_mom_z        <= s4_side_ff.pz;
      end
   end

   assign rsp_chan.valid   = out_vld_ff;
   assign rsp_chan.payload = out_ff;

   // a held response blocks new requests
   a_stall_blocks_req: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.ready) |-> !req_chan.ready)
      else $error("request accepted while response stalled");

   // reset empties the output
   a_reset_empties: assert property (@(posedge clock)
      reset |=> !rsp_chan.valid)
      else $error("response valid right after reset");

   // a frozen pipeline keeps its first stage and output valid bits
   a_freeze_holds: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(s1_vld_ff) && $stable(out_vld_ff))
      else $error("pipeline moved while stalled");

endmodule
